/* rtl/core/a2oct_pkg.sv */
`default_nettype none

package a2oct_pkg;

  localparam int unsigned NUM_CELLS = 16;

  localparam logic [14:0] PI_4 = 15'd25736;
  localparam logic [13:0] C1   = 14'd8017;
  localparam logic [11:0] C2   = 12'd2172;
  localparam logic [16:0] PI   = 17'd102944;
  localparam logic [15:0] PI_2 = 16'd51472;
  localparam logic [15:0] ONE  = 16'd32768;

  typedef struct packed {
    logic zero;
    logic swap;
    logic xneg;
    logic yneg;
  } oct_flags_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] dvsr;
    logic [15:0] quo;
    oct_flags_t  flags;
  } div_word_t;

endpackage

`default_nettype wire

/* rtl/core/a2oct_prep.sv */
`default_nettype none

module a2oct_prep (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [31:0]           imag_part,
  input  wire logic [31:0]           real_part,
  input  wire logic                  down_en,
  output logic                       en,
  output logic                       valid,
  output a2oct_pkg::div_word_t       word
);
  import a2oct_pkg::*;

  logic [31:0] ax;
  logic [31:0] ay;
  logic        swap;
  div_word_t   word_next;

  always_comb begin
    ax   = real_part[31] ? (~real_part + 32'd1) : real_part;
    ay   = imag_part[31] ? (~imag_part + 32'd1) : imag_part;
    swap = ay > ax;
    word_next.rem        = {1'b0, (swap ? ax : ay)};
    word_next.dvsr       = swap ? ay : ax;
    word_next.quo        = '0;
    word_next.flags.zero = (real_part == 32'd0) && (imag_part == 32'd0);
    word_next.flags.swap = swap;
    word_next.flags.xneg = real_part[31];
    word_next.flags.yneg = imag_part[31];
  end

  assign en = !valid || down_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word <= word_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/a2oct_div_cell.sv */
`default_nettype none

module a2oct_div_cell (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire a2oct_pkg::div_word_t  in_word,
  input  wire logic                  down_en,
  output logic                       en,
  output logic                       valid,
  output a2oct_pkg::div_word_t       word
);
  import a2oct_pkg::*;

  logic        q;
  logic [32:0] diff;
  logic [32:0] rest;
  div_word_t   word_next;

  // one quotient bit: compare, subtract, shift
  always_comb begin
    diff = in_word.rem - {1'b0, in_word.dvsr};
    q    = in_word.rem >= {1'b0, in_word.dvsr};
    rest = q ? diff : in_word.rem;
    word_next       = in_word;
    word_next.rem   = {rest[31:0], 1'b0};
    word_next.quo   = {in_word.quo[14:0], q};
  end

  assign en = !valid || down_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word <= word_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/a2oct_poly.sv */
`default_nettype none

module a2oct_poly (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [15:0]           ratio,
  input  wire a2oct_pkg::oct_flags_t in_flags,
  input  wire logic                  down_en,
  output logic                       en,
  output logic                       valid,
  output logic signed [17:0]         angle
);
  import a2oct_pkg::*;

  logic        v1, v2, v3;
  logic        en1, en2, en3, en4;
  oct_flags_t  f1, f2, f3;

  logic [31:0] lin_prod;
  logic [31:0] bow_prod;
  logic [31:0] t_prod;
  logic [15:0] om;
  logic [14:0] lin1, lin2;
  logic [13:0] bow1;
  logic [11:0] t1;

  logic [14:0] coef;
  logic [31:0] corr_prod;
  logic [11:0] corr2;

  logic [15:0] ang;
  logic [16:0] oct_next;
  logic [16:0] oct3;

  logic [16:0]        half;
  logic signed [17:0] angle_next;

  assign en4 = !valid || down_en;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en  = en1;

  always_comb begin
    om       = ONE - ratio;
    lin_prod = 32'(ratio) * 32'(PI_4);
    bow_prod = 32'(ratio) * 32'(om);
    t_prod   = 32'(ratio) * 32'(C2);
  end

  always_comb begin
    coef      = {1'b0, C1} + {3'b0, t1};
    corr_prod = 32'(bow1) * 32'(coef);
  end

  always_comb begin
    ang      = {1'b0, lin2} + {4'b0, corr2};
    oct_next = f2.swap ? ({1'b0, PI_2} - {1'b0, ang}) : {1'b0, ang};
  end

  always_comb begin
    half = f3.xneg ? (PI - oct3) : oct3;
    if (f3.zero) begin
      angle_next = '0;
    end else if (f3.yneg) begin
      angle_next = -$signed({1'b0, half});
    end else begin
      angle_next = $signed({1'b0, half});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      lin1 <= lin_prod[29:15];
      bow1 <= bow_prod[28:15];
      t1   <= t_prod[26:15];
      f1   <= in_flags;
    end
    if (en2) begin
      lin2  <= lin1;
      corr2 <= corr_prod[26:15];
      f2    <= f1;
    end
    if (en3) begin
      oct3 <= oct_next;
      f3   <= f2;
    end
    if (en4) begin
      angle <= angle_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/atan2_octant_polynomial_q15_unit.sv */
// registers from an accepted word to out_valid: 1 prep, 16 divider cells, 4 poly
// throughput: one word per cycle without stalls; the divider is a row of 16 cells, one quotient bit each
// every stage holds its own valid bit, so stall closes bubbles as it ripples back
// in_stall rises only when every stage is full and the output word is stalled
// reset: rst is synchronous, active high, and clears the valid bits only
`default_nettype none

module atan2_octant_polynomial_q15_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] imag_part,
  input  wire logic signed [31:0] real_part,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [17:0]      angle
);
  import a2oct_pkg::*;

  div_word_t cw  [0:NUM_CELLS];
  logic      cv  [0:NUM_CELLS];
  logic      cen [0:NUM_CELLS];
  logic      prep_en;

  a2oct_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .imag_part (imag_part),
    .real_part (real_part),
    .down_en   (cen[0]),
    .en        (prep_en),
    .valid     (cv[0]),
    .word      (cw[0])
  );

  assign in_stall = !prep_en;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    a2oct_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cv[k]),
      .in_word  (cw[k]),
      .down_en  (cen[k + 1]),
      .en       (cen[k]),
      .valid    (cv[k + 1]),
      .word     (cw[k + 1])
    );
  end

  a2oct_poly u_poly (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cv[NUM_CELLS]),
    .ratio    (cw[NUM_CELLS].quo),
    .in_flags (cw[NUM_CELLS].flags),
    .down_en  (!out_stall),
    .en       (cen[NUM_CELLS]),
    .valid    (out_valid),
    .angle    (angle)
  );

  a_angle_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle <= $signed({1'b0, PI})) && (angle >= -$signed({1'b0, PI})))
    else $error("angle outside -pi..pi");

  a_ratio_range : assert property (@(posedge clk) disable iff (rst)
    cv[NUM_CELLS] && !cw[NUM_CELLS].flags.zero |-> cw[NUM_CELLS].quo <= ONE)
    else $error("ratio above one");

  a_prep_order : assert property (@(posedge clk) disable iff (rst)
    cv[0] && !cw[0].flags.zero |->
      (cw[0].dvsr != 32'd0) && (cw[0].rem <= {1'b0, cw[0].dvsr}))
    else $error("min above max after prep");

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

endmodule

`default_nettype wire

/* verif/atan2_octant_polynomial_q15_unit_test.sv */
`timescale 1ns / 100ps

module atan2_octant_polynomial_q15_unit_test;

  localparam longint ATAN_PI_4 = 25736;
  localparam longint ATAN_C1   = 8017;
  localparam longint ATAN_C2   = 2172;
  localparam longint ATAN_PI   = 102944;
  localparam longint ATAN_PI_2 = 51472;
  localparam longint ATAN_ONE  = 32768;

  localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] NEG_MAX = 32'sh80000001;
  localparam int RANDOM_PER_PHASE = 400;

  typedef struct packed {
    logic signed [31:0] im;
    logic signed [31:0] re;
    bit                 known;
    logic signed [17:0] ang;
  } angle_row_t;

  localparam int NUM_ROWS = 25;

  // known answers only where they follow directly: zeros, axes, diagonals
  localparam angle_row_t ANGLE_ROWS [NUM_ROWS] = '{
    '{32'sd0,        32'sd0,        1'b1, 18'sd0},
    '{32'sd0,        32'sd1,        1'b1, 18'sd0},
    '{32'sd0,        -32'sd1,       1'b1, 18'sd102944},
    '{32'sd1,        32'sd0,        1'b1, 18'sd51472},
    '{-32'sd1,       32'sd0,        1'b1, -18'sd51472},
    '{32'sd1,        32'sd1,        1'b1, 18'sd25736},
    '{32'sd1,        -32'sd1,       1'b1, 18'sd77208},
    '{-32'sd1,       -32'sd1,       1'b1, -18'sd77208},
    '{-32'sd1,       32'sd1,        1'b1, -18'sd25736},
    '{POS_MAX,       POS_MAX,       1'b1, 18'sd25736},
    '{NEG_MAX,       NEG_MAX,       1'b1, -18'sd77208},
    '{32'sd0,        POS_MAX,       1'b1, 18'sd0},
    '{32'sd0,        NEG_MAX,       1'b1, 18'sd102944},
    '{POS_MAX,       32'sd0,        1'b1, 18'sd51472},
    '{NEG_MAX,       32'sd0,        1'b1, -18'sd51472},
    '{32'sd1,        POS_MAX,       1'b0, 18'sd0},
    '{POS_MAX,       32'sd1,        1'b0, 18'sd0},
    '{NEG_MAX,       32'sd1,        1'b0, 18'sd0},
    '{32'sd1,        NEG_MAX,       1'b0, 18'sd0},
    '{-32'sd1,       NEG_MAX,       1'b0, 18'sd0},
    '{32'sh7FFFFFFE, POS_MAX,       1'b0, 18'sd0},
    '{POS_MAX,       32'sh7FFFFFFE, 1'b0, 18'sd0},
    '{32'sh55555555, 32'sh2AAAAAAA, 1'b0, 18'sd0},
    '{32'shAAAAAAAB, 32'shD5555556, 1'b0, 18'sd0},
    '{32'sd12345,    -32'sd67890,   1'b0, 18'sd0}
  };

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic signed [31:0]  imag_part;
  logic signed [31:0]  real_part;
  logic                out_valid;
  logic                out_stall;
  logic signed [17:0]  angle;

  logic signed [17:0]  pending_angle;
  logic signed [17:0]  expected_angles [$];
  int                  mismatch_count;
  int                  sender_idle_pct;
  int                  receiver_stall_pct;

  atan2_octant_polynomial_q15_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .imag_part (imag_part),
    .real_part (real_part),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .angle     (angle)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [17:0] predict_angle(logic signed [31:0] y,
                                                       logic signed [31:0] x);
    longint sy, sx, ay, ax, mn, mx, ratio, lin, bow, corr, ang;
    sy = y;
    sx = x;
    if (sy == 0 && sx == 0) begin
      return 18'sd0;
    end
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    mn = (ax < ay) ? ax : ay;
    mx = (ax < ay) ? ay : ax;
    ratio = (mn <<< 15) / mx;
    lin = (ratio * ATAN_PI_4) >>> 15;
    bow = (ratio * (ATAN_ONE - ratio)) >>> 15;
    corr = (bow * (ATAN_C1 + ((ATAN_C2 * ratio) >>> 15))) >>> 15;
    ang = lin + corr;
    if (ay > ax) begin
      ang = ATAN_PI_2 - ang;
    end
    if (sx < 0) begin
      ang = ATAN_PI - ang;
    end
    if (sy < 0) begin
      ang = -ang;
    end
    return ang[17:0];
  endfunction

  function automatic logic signed [31:0] random_component();
    logic signed [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $signed($urandom_range(32)) - 32'sd16;
      2: v = POS_MAX - $signed($urandom_range(15));
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1) == 1 && v != 32'sh80000000) begin
      v = -v;
    end
    if (v == 32'sh80000000) begin
      v = NEG_MAX;
    end
    return v;
  endfunction

  task automatic send_word(input logic signed [31:0] im, input logic signed [31:0] re,
                           input logic signed [17:0] exp_ang);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    imag_part     <= im;
    real_part     <= re;
    pending_angle <= exp_ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct);
    logic signed [31:0] im, re;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      case ($urandom_range(9))
        6, 7: begin
          im = random_component();
          re = ($urandom_range(1) == 1) ? -im : im;
        end
        8: begin
          im = random_component();
          re = random_component();
          if ($urandom_range(1) == 1) im = 32'sd0;
          else re = 32'sd0;
        end
        9: begin
          im = random_component();
          re = im >>> $urandom_range(31);
          if ($urandom_range(1) == 1) begin
            re = -re;
          end
          if ($urandom_range(1) == 1) begin
            {im, re} = {re, im};
          end
        end
        default: begin
          im = random_component();
          re = random_component();
        end
      endcase
      send_word(im, re, predict_angle(im, re));
    end
    drain_words();
  endtask

  // stall pattern for the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // scoreboard: accepted input words in, accepted result words out
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_angles.push_back(pending_angle);
      end
      if (out_valid && !out_stall) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %0d", $time, angle);
          mismatch_count++;
        end else begin
          if (angle !== expected_angles[0]) begin
            $display("%0t: angle mismatch, expected %0d, actual %0d",
                     $time, expected_angles[0], angle);
            mismatch_count++;
          end
          void'(expected_angles.pop_front());
        end
      end
    end
  end

  initial begin
    rst                = 1'b1;
    in_valid           = 1'b0;
    imag_part          = 32'sd0;
    real_part          = 32'sd0;
    out_stall          = 1'b0;
    pending_angle      = 18'sd0;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_word(ANGLE_ROWS[i].im, ANGLE_ROWS[i].re,
                ANGLE_ROWS[i].known ? ANGLE_ROWS[i].ang
                                    : predict_angle(ANGLE_ROWS[i].im, ANGLE_ROWS[i].re));
    end
    drain_words();

    random_phase(0, 0);
    random_phase(69, 0);
    random_phase(0, 69);
    random_phase(11, 11);

    // let any stray word show up
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/a2oct_pkg.sv
rtl/core/a2oct_prep.sv
rtl/core/a2oct_div_cell.sv
rtl/core/a2oct_poly.sv
rtl/core/atan2_octant_polynomial_q15_unit.sv
verif/atan2_octant_polynomial_q15_unit_test.sv
